@@ hw/rtl/bpa_pkg.sv @@
`default_nettype none

package bpa_pkg;

  // Field widths of the request, result and configuration items
  localparam int MODE_W    = 2;
  localparam int ADDR_W    = 48;
  localparam int PCOUNT_W  = 36;
  localparam int RTYPE_W   = 4;
  localparam int PADDR_W   = 28;
  localparam int STATUS_W  = 2;
  localparam int FREE_W    = 17;
  localparam int TOTAL_W   = 48;
  localparam int RSV_W     = 17;

  // Fixed 4 KiB pages, 64-bit map words
  localparam int PAGE_SHIFT = 12;
  localparam int PAGE_IDX_W = ADDR_W - PAGE_SHIFT;
  localparam int WORD_BITS  = 64;
  localparam int WORD_SHIFT = 6;

  localparam logic [RSV_W-1:0]   RESERVED_RESET = 17'd1024;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX      = 48'hFFFF_FFFF_FFFF;
  localparam logic [FREE_W-1:0]  FREE_MAX       = 17'h1FFFF;

  // Usable memory types
  localparam logic [RTYPE_W-1:0] RTYPE_BOOT_CODE    = 4'd3;
  localparam logic [RTYPE_W-1:0] RTYPE_BOOT_DATA    = 4'd4;
  localparam logic [RTYPE_W-1:0] RTYPE_CONVENTIONAL = 4'd7;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_REGION = 2'd2,
    MODE_NOP    = 2'd3
  } bpa_mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_NO_MEM      = 2'd1,
    ST_RANGE       = 2'd2,
    ST_DOUBLE_FREE = 2'd3
  } bpa_status_t;

  // Controller to datapath
  typedef struct packed {
    logic        latch;     // capture request fields
    logic        clr_wr;    // write an all-used word at the pointer
    logic        ptr_zero;  // point at map word zero
    logic        ptr_free;  // point at the word of the page to free
    logic        setup;     // add region size, form range bounds
    logic        range_ld;  // load clamped range, point at its first word
    logic        ptr_inc;   // advance the word pointer
    logic        rd;        // read the map word at the pointer
    logic        apply;     // update the word just read
    logic        set_st;    // record a result status
    bpa_status_t st;
    logic        load_out;  // move the result into the output register
  } bpa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    bpa_mode_t mode;
    logic      free_oor;     // page to free lies past the map
    logic      range_empty;  // region frees nothing
    logic      hit;          // alloc: word has a free page; free: page is used
    logic      ptr_end;      // pointer at the last map word
    logic      ptr_last;     // pointer at the last word of the region
  } bpa_stat_t;

  function automatic logic [6:0] popcount64(input logic [63:0] v);
    logic [6:0] sum;
    logic [3:0] grp;
    sum = '0;
    for (int g = 0; g < 8; g++) begin
      grp = '0;
      for (int b = 0; b < 8; b++) begin
        grp = grp + 4'(v[g*8+b]);
      end
      sum = sum + 7'(grp);
    end
    return sum;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bpa_if.sv @@
`default_nettype none

// Request channel
interface bpa_req_if;
  logic                           valid;
  logic                           ready;
  logic [bpa_pkg::MODE_W-1:0]     mode;
  logic [bpa_pkg::ADDR_W-1:0]     address;
  logic [bpa_pkg::PCOUNT_W-1:0]   page_count;
  logic [bpa_pkg::RTYPE_W-1:0]    region_type;

  modport source (output valid, mode, address, page_count, region_type, input ready);
  modport sink   (input valid, mode, address, page_count, region_type, output ready);
endinterface

// Result channel
interface bpa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [bpa_pkg::PADDR_W-1:0]    page_address;
  logic [bpa_pkg::STATUS_W-1:0]   status;
  logic [bpa_pkg::FREE_W-1:0]     free_pages;
  logic [bpa_pkg::TOTAL_W-1:0]    total_bytes;

  modport source (output valid, page_address, status, free_pages, total_bytes, input ready);
  modport sink   (input valid, page_address, status, free_pages, total_bytes, output ready);
endinterface

// Configuration write channel
interface bpa_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bpa_pkg::RSV_W-1:0]      data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/bpa_ram.sv @@
`default_nettype none

module bpa_ram #(
  parameter  int WIDTH = 64,
  parameter  int DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [AW-1:0]          waddr,
  input  wire logic [WIDTH-1:0]       wdata,
  input  wire logic                   re,
  input  wire logic [AW-1:0]          raddr,
  output logic      [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/bpa_dp.sv @@
`default_nettype none

module bpa_dp #(
  parameter int MAP_PAGES = 65536
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire bpa_pkg::bpa_cmd_t                cmd,
  output bpa_pkg::bpa_stat_t                    stat,
  input  wire logic [bpa_pkg::MODE_W-1:0]       req_mode,
  input  wire logic [bpa_pkg::ADDR_W-1:0]       req_address,
  input  wire logic [bpa_pkg::PCOUNT_W-1:0]     req_page_count,
  input  wire logic [bpa_pkg::RTYPE_W-1:0]      req_region_type,
  input  wire logic                             cfg_we,
  input  wire logic [bpa_pkg::RSV_W-1:0]        cfg_data,
  output logic      [bpa_pkg::PADDR_W-1:0]      out_page_address,
  output logic      [bpa_pkg::STATUS_W-1:0]     out_status,
  output logic      [bpa_pkg::FREE_W-1:0]       out_free_pages,
  output logic      [bpa_pkg::TOTAL_W-1:0]      out_total_bytes
);

  localparam int WB        = bpa_pkg::WORD_BITS;
  localparam int MAP_WORDS = (MAP_PAGES + WB - 1) / WB;
  localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PW        = $clog2(MAP_PAGES);
  localparam int CW        = $clog2(MAP_PAGES + 1);
  localparam int IW        = bpa_pkg::PAGE_IDX_W;
  localparam int RW        = IW + 1;

  // Request and working registers
  bpa_pkg::bpa_mode_t          mode_r;
  logic [IW-1:0]               page_r;
  logic [IW-1:0]               cnt_r;
  logic                        usable_r;
  logic [RW-1:0]               lo_w_r, end_w_r;
  logic [PW-1:0]               lo_r, last_r;
  logic [WW-1:0]               wptr_r;
  logic [CW-1:0]               count_r;
  logic [bpa_pkg::TOTAL_W-1:0] total_r;
  logic [bpa_pkg::RSV_W-1:0]   reserved_r;
  logic [bpa_pkg::PADDR_W-1:0] res_addr_r;
  bpa_pkg::bpa_status_t        res_status_r;

  // Map memory
  logic            ram_we;
  logic [WB-1:0]   ram_wdata;
  logic [WB-1:0]   word;

  bpa_ram #(
    .WIDTH (WB),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wptr_r),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (wptr_r),
    .rdata (word)
  );

  // Lowest free page in the word read
  logic [5:0] zidx;
  always_comb begin
    zidx = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (!word[i]) begin
        zidx = 6'(i);
      end
    end
  end

  // Region bounds within the current word
  logic [PW-1:0] lo_sh, last_sh;
  logic [WW-1:0] lo_wd, last_wd;
  logic [5:0]    lo_b, hi_b;
  logic [WB-1:0] mask;
  logic [6:0]    freed;

  assign lo_sh   = lo_r >> bpa_pkg::WORD_SHIFT;
  assign last_sh = last_r >> bpa_pkg::WORD_SHIFT;
  assign lo_wd   = lo_sh[WW-1:0];
  assign last_wd = last_sh[WW-1:0];
  assign lo_b    = (wptr_r == lo_wd) ? lo_r[5:0] : 6'd0;
  assign hi_b    = (wptr_r == last_wd) ? last_r[5:0] : 6'd63;
  assign mask    = ({WB{1'b1}} << lo_b) & ({WB{1'b1}} >> (6'd63 - hi_b));
  assign freed   = bpa_pkg::popcount64(word & mask);

  // Range setup and clamp
  logic [RW-1:0] first_w, rsv_w, hi_w, hi_m1, lo_sw;
  logic [IW-1:0] page_sh;
  logic [bpa_pkg::TOTAL_W:0] tot_sum;

  assign first_w = {1'b0, page_r};
  assign rsv_w   = RW'(reserved_r);
  assign hi_w    = (end_w_r > RW'(MAP_PAGES)) ? RW'(MAP_PAGES) : end_w_r;
  assign hi_m1   = hi_w - RW'(1);
  assign lo_sw   = lo_w_r >> bpa_pkg::WORD_SHIFT;
  assign page_sh = page_r >> bpa_pkg::WORD_SHIFT;
  assign tot_sum = {1'b0, total_r} + {1'b0, cnt_r, {bpa_pkg::PAGE_SHIFT{1'b0}}};

  // Hit per request kind
  logic hit;
  assign hit = (mode_r == bpa_pkg::MODE_ALLOC) ? !(&word) : word[page_r[5:0]];

  // Status toward the controller
  always_comb begin
    stat             = '0;
    stat.mode        = mode_r;
    stat.free_oor    = page_r >= IW'(MAP_PAGES);
    stat.range_empty = !usable_r || (lo_w_r >= hi_w);
    stat.hit         = hit;
    stat.ptr_end     = wptr_r == WW'(MAP_WORDS - 1);
    stat.ptr_last    = wptr_r == last_wd;
  end

  // Map word write-back
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = {WB{1'b1}};
    if (cmd.clr_wr) begin
      ram_we = 1'b1;
    end else if (cmd.apply) begin
      case (mode_r)
        bpa_pkg::MODE_ALLOC: begin
          ram_we    = hit;
          ram_wdata = word | (WB'(1) << zidx);
        end
        bpa_pkg::MODE_FREE: begin
          ram_we    = hit;
          ram_wdata = word & ~(WB'(1) << page_r[5:0]);
        end
        bpa_pkg::MODE_REGION: begin
          ram_we    = 1'b1;
          ram_wdata = word & ~mask;
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  // Allocated page byte address
  logic [WW+5:0] alloc_page;
  logic [63:0]   alloc_bytes;
  assign alloc_page  = {wptr_r, zidx};
  assign alloc_bytes = 64'(alloc_page) << bpa_pkg::PAGE_SHIFT;

  // Control-side registers: pointer, count, total, reserved boundary
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r     <= '0;
      count_r    <= '0;
      total_r    <= '0;
      reserved_r <= bpa_pkg::RESERVED_RESET;
    end else begin
      if (cfg_we) begin
        reserved_r <= cfg_data;
      end
      if (cmd.ptr_zero) begin
        wptr_r <= '0;
      end else if (cmd.ptr_free) begin
        wptr_r <= page_sh[WW-1:0];
      end else if (cmd.range_ld) begin
        wptr_r <= lo_sw[WW-1:0];
      end else if (cmd.ptr_inc) begin
        wptr_r <= wptr_r + WW'(1);
      end
      if (cmd.setup) begin
        total_r <= tot_sum[bpa_pkg::TOTAL_W] ? bpa_pkg::TOTAL_MAX
                                             : tot_sum[bpa_pkg::TOTAL_W-1:0];
      end
      if (cmd.apply) begin
        case (mode_r)
          bpa_pkg::MODE_ALLOC:  if (hit) count_r <= count_r - CW'(1);
          bpa_pkg::MODE_FREE:   if (hit) count_r <= count_r + CW'(1);
          bpa_pkg::MODE_REGION: count_r <= count_r + CW'(freed);
          default:              count_r <= count_r;
        endcase
      end
    end
  end

  // Request capture, range bounds and result
  logic [31:0] count_ext;
  assign count_ext = 32'(count_r);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mode_r       <= bpa_pkg::bpa_mode_t'(req_mode);
      page_r       <= req_address[bpa_pkg::ADDR_W-1:bpa_pkg::PAGE_SHIFT];
      cnt_r        <= req_page_count;
      usable_r     <= (req_region_type == bpa_pkg::RTYPE_CONVENTIONAL) ||
                      (req_region_type == bpa_pkg::RTYPE_BOOT_CODE) ||
                      (req_region_type == bpa_pkg::RTYPE_BOOT_DATA);
      res_addr_r   <= '0;
      res_status_r <= bpa_pkg::ST_OK;
    end
    if (cmd.setup) begin
      lo_w_r  <= (first_w < rsv_w) ? rsv_w : first_w;
      end_w_r <= first_w + {1'b0, cnt_r};
    end
    if (cmd.range_ld) begin
      lo_r   <= lo_w_r[PW-1:0];
      last_r <= hi_m1[PW-1:0];
    end
    if (cmd.apply && (mode_r == bpa_pkg::MODE_ALLOC) && hit) begin
      res_addr_r <= alloc_bytes[bpa_pkg::PADDR_W-1:0];
    end
    if (cmd.set_st) begin
      res_status_r <= cmd.st;
    end
    if (cmd.load_out) begin
      out_page_address <= res_addr_r;
      out_status       <= res_status_r;
      out_free_pages   <= (count_ext > 32'(bpa_pkg::FREE_MAX)) ? bpa_pkg::FREE_MAX
                                                               : count_ext[bpa_pkg::FREE_W-1:0];
      out_total_bytes  <= total_r;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAP_PAGES))
    else $error("free page count exceeds the number of pages");

  a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    total_r >= $past(total_r))
    else $error("region byte total decreased");

  a_alloc_word_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.apply && mode_r == bpa_pkg::MODE_ALLOC && hit) |-> !word[zidx])
    else $error("allocation picked a page that is already used");

endmodule

`default_nettype wire

@@ hw/rtl/bpa_ctrl.sv @@
`default_nettype none

module bpa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bpa_pkg::bpa_cmd_t       cmd,
  input  wire bpa_pkg::bpa_stat_t stat
);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_DISP,
    S_RANGE,
    S_RD,
    S_CHK,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      // Sweep the map to all-used after reset
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (stat.ptr_end) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.mode)
          bpa_pkg::MODE_ALLOC: begin
            cmd.ptr_zero = 1'b1;
            state_nxt    = S_RD;
          end
          bpa_pkg::MODE_FREE: begin
            if (stat.free_oor) begin
              cmd.set_st = 1'b1;
              cmd.st     = bpa_pkg::ST_RANGE;
              state_nxt  = S_DONE;
            end else begin
              cmd.ptr_free = 1'b1;
              state_nxt    = S_RD;
            end
          end
          bpa_pkg::MODE_REGION: begin
            cmd.setup = 1'b1;
            state_nxt = S_RANGE;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_RANGE: begin
        if (stat.range_empty) begin
          state_nxt = S_DONE;
        end else begin
          cmd.range_ld = 1'b1;
          state_nxt    = S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CHK;
      end
      // Update the word and decide whether to walk on
      S_CHK: begin
        cmd.apply = 1'b1;
        state_nxt = S_DONE;
        case (stat.mode)
          bpa_pkg::MODE_ALLOC: begin
            if (!stat.hit) begin
              if (stat.ptr_end) begin
                cmd.set_st = 1'b1;
                cmd.st     = bpa_pkg::ST_NO_MEM;
              end else begin
                cmd.ptr_inc = 1'b1;
                state_nxt   = S_RD;
              end
            end
          end
          bpa_pkg::MODE_FREE: begin
            if (!stat.hit) begin
              cmd.set_st = 1'b1;
              cmd.st     = bpa_pkg::ST_DOUBLE_FREE;
            end
          end
          bpa_pkg::MODE_REGION: begin
            if (!stat.ptr_last) begin
              cmd.ptr_inc = 1'b1;
              state_nxt   = S_RD;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      // Hold until the output register is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Checks
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over an item not yet taken");

  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result shown without finishing a request");

  a_walk_from_check: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ptr_inc |-> (state_r == S_CHK || state_r == S_CLR))
    else $error("word pointer moved outside a map walk");

endmodule

`default_nettype wire

@@ hw/rtl/bitmap_page_allocator_top.sv @@
`default_nettype none

// First-fit physical page allocator over a one-bit-per-page used map held in a
// single-port-read RAM of 64-bit words (MAP_PAGES/64 words). After reset every
// page is used and the block runs a clearing pass over every map word before it
// takes its first request; configuration writes to reserved_pages are taken at
// any time but are meant for idle periods. Each request gives one result. A
// no-op or an out-of-range free goes straight to the result; a free reads one
// map word and updates it; an allocate scans map words from word zero up to
// the first word with a free page (every word when memory is full); a region
// walks each map word it spans (none when it frees nothing). Each map word is
// read through the registered RAM port and then updated. One request is in
// flight at a time; a finished result waits in the output register while the
// next request is accepted and worked on.
module bitmap_page_allocator_top #(
  parameter int MAP_PAGES = 65536
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bpa_req_if.sink    in_req,
  bpa_rsp_if.source  out_rsp,
  bpa_cfg_if.sink    cfg_wr
);

  bpa_pkg::bpa_cmd_t  cmd;
  bpa_pkg::bpa_stat_t stat;

  // Configuration is always taken
  assign cfg_wr.ready = 1'b1;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  bpa_dp #(
    .MAP_PAGES (MAP_PAGES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .req_mode         (in_req.mode),
    .req_address      (in_req.address),
    .req_page_count   (in_req.page_count),
    .req_region_type  (in_req.region_type),
    .cfg_we           (cfg_wr.valid),
    .cfg_data         (cfg_wr.data),
    .out_page_address (out_rsp.page_address),
    .out_status       (out_rsp.status),
    .out_free_pages   (out_rsp.free_pages),
    .out_total_bytes  (out_rsp.total_bytes)
  );

endmodule

`default_nettype wire

@@ test/bitmap_page_allocator_top_tb.sv @@
`default_nettype none

module bitmap_page_allocator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bpa_pkg::*;

  localparam int MAP_PAGES  = 65536;
  localparam int PAGE_BYTES = 4096;
  localparam int MAP_WORDS  = MAP_PAGES / WORD_BITS;
  localparam int CYCLE_LIMIT = 12_000_000;
  localparam int PHASE_ITEMS = 425;

  // Memory types that the block keeps used
  localparam logic [RTYPE_W-1:0] RTYPE_RESERVED     = 4'd0;
  localparam logic [RTYPE_W-1:0] RTYPE_RUNTIME_CODE = 4'd5;
  localparam logic [RTYPE_W-1:0] RTYPE_TOP_CODE     = 4'd15;

  typedef struct packed {
    bpa_mode_t             mode;
    logic [ADDR_W-1:0]     address;
    logic [PCOUNT_W-1:0]   page_count;
    logic [RTYPE_W-1:0]    region_type;
  } page_req_t;

  typedef struct packed {
    logic [PADDR_W-1:0]    page_address;
    bpa_status_t           status;
    logic [FREE_W-1:0]     free_pages;
    logic [TOTAL_W-1:0]    total_bytes;
  } page_rsp_t;

  // Page map predictor and result checker
  class page_alloc_scoreboard;
    logic [WORD_BITS-1:0] used_words [MAP_WORDS];
    int unsigned          free_cnt;
    longint unsigned      total;
    int unsigned          reserved;
    page_rsp_t            pending_results [$];
    int unsigned          held_pages [$];
    int                   mode_count [4];
    int                   errors;
    int                   checked;

    function new();
      for (int w = 0; w < MAP_WORDS; w++) used_words[w] = '1;
      free_cnt = 0;
      total    = 0;
      reserved = RESERVED_RESET;
      errors   = 0;
      checked  = 0;
      for (int m = 0; m < 4; m++) mode_count[m] = 0;
    endfunction

    function void set_reserved(int unsigned v);
      reserved = v;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Apply one accepted request to the map and queue its result
    function void note_request(page_req_t r);
      page_rsp_t       e;
      longint unsigned pg;
      longint unsigned first;
      longint unsigned last;
      longint unsigned sum;
      bit              found;
      e.page_address = '0;
      e.status       = ST_OK;
      mode_count[r.mode]++;
      case (r.mode)
        MODE_ALLOC: begin
          found = 0;
          for (int w = 0; w < MAP_WORDS && !found; w++) begin
            if (used_words[w] != '1) begin
              for (int b = 0; b < WORD_BITS && !found; b++) begin
                if (!used_words[w][b]) begin
                  used_words[w][b] = 1'b1;
                  free_cnt--;
                  e.page_address = PADDR_W'((w * WORD_BITS + b) * PAGE_BYTES);
                  held_pages.push_back(w * WORD_BITS + b);
                  found = 1;
                end
              end
            end
          end
          if (!found) e.status = ST_NO_MEM;
        end
        MODE_FREE: begin
          pg = longint'(r.address) >> PAGE_SHIFT;
          if (pg >= MAP_PAGES) begin
            e.status = ST_RANGE;
          end else if (!used_words[pg >> WORD_SHIFT][pg[5:0]]) begin
            e.status = ST_DOUBLE_FREE;
          end else begin
            used_words[pg >> WORD_SHIFT][pg[5:0]] = 1'b0;
            free_cnt++;
          end
        end
        MODE_REGION: begin
          sum   = total + (longint'(r.page_count) << PAGE_SHIFT);
          total = (sum > longint'(TOTAL_MAX)) ? longint'(TOTAL_MAX) : sum;
          if (r.region_type == RTYPE_CONVENTIONAL || r.region_type == RTYPE_BOOT_CODE ||
              r.region_type == RTYPE_BOOT_DATA) begin
            first = longint'(r.address) >> PAGE_SHIFT;
            last  = first + longint'(r.page_count);
            if (first < reserved) first = reserved;
            if (last > MAP_PAGES) last = MAP_PAGES;
            for (pg = first; pg < last; pg++) begin
              if (used_words[pg >> WORD_SHIFT][pg[5:0]]) begin
                used_words[pg >> WORD_SHIFT][pg[5:0]] = 1'b0;
                free_cnt++;
              end
            end
          end
        end
        default: ;
      endcase
      e.free_pages  = (free_cnt > FREE_MAX) ? FREE_MAX : FREE_W'(free_cnt);
      e.total_bytes = TOTAL_W'(total);
      pending_results.push_back(e);
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(page_rsp_t got);
      page_rsp_t e;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("tb: result with nothing expected: addr %h st %0d free %0d total %h",
                   got.page_address, got.status, got.free_pages, got.total_bytes);
        return;
      end
      e = pending_results.pop_front();
      checked++;
      if (got.page_address !== e.page_address || got.status !== e.status ||
          got.free_pages !== e.free_pages || got.total_bytes !== e.total_bytes) begin
        errors++;
        if (errors <= 10) begin
          $display("tb: mismatch on result %0d", checked);
          $display("  expected addr %h st %0d free %0d total %h",
                   e.page_address, e.status, e.free_pages, e.total_bytes);
          $display("  actual   addr %h st %0d free %0d total %h",
                   got.page_address, got.status, got.free_pages, got.total_bytes);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   idle_pct;
  int   cycles;
  int   cfg_writes;

  page_alloc_scoreboard sb;

  bpa_req_if in_req ();
  bpa_rsp_if out_rsp ();
  bpa_cfg_if cfg_wr ();

  bitmap_page_allocator_top #(
    .MAP_PAGES (MAP_PAGES)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp),
    .cfg_wr  (cfg_wr)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  // Stall the result channel at random
  always @(negedge clk) begin
    out_rsp.ready <= ($urandom_range(99) >= idle_pct);
  end

  // Check every accepted result
  always @(posedge clk) begin : result_mon
    page_rsp_t got;
    if (out_rsp.valid === 1'b1 && out_rsp.ready === 1'b1) begin
      got.page_address = out_rsp.page_address;
      got.status       = bpa_status_t'(out_rsp.status);
      got.free_pages   = out_rsp.free_pages;
      got.total_bytes  = out_rsp.total_bytes;
      sb.check_result(got);
    end
  end

  function automatic page_req_t mk(bpa_mode_t m, logic [ADDR_W-1:0] a,
                                   logic [PCOUNT_W-1:0] n, logic [RTYPE_W-1:0] t);
    page_req_t r;
    r.mode        = m;
    r.address     = a;
    r.page_count  = n;
    r.region_type = t;
    return r;
  endfunction

  // Mostly allocations, frees of held pages and small usable regions
  function automatic page_req_t random_req();
    page_req_t   r;
    int unsigned sel;
    int unsigned k;
    int unsigned pg;
    r.mode        = MODE_NOP;
    r.address     = ADDR_W'({$urandom(), $urandom()});
    r.page_count  = PCOUNT_W'({$urandom(), $urandom()});
    r.region_type = RTYPE_W'($urandom_range(15));
    sel = $urandom_range(99);
    if (sel < 36) begin
      r.mode = MODE_ALLOC;
    end else if (sel < 62) begin
      r.mode = MODE_FREE;
      if (sb.held_pages.size() > 0) begin
        k = $urandom_range(sb.held_pages.size() - 1);
        pg = sb.held_pages[k];
        sb.held_pages.delete(k);
        r.address = (ADDR_W'(pg) << PAGE_SHIFT) | ADDR_W'($urandom_range(PAGE_BYTES - 1));
      end
    end else if (sel < 68) begin
      r.mode = MODE_FREE;
      if ($urandom_range(1))
        r.address = (ADDR_W'($urandom_range(MAP_PAGES - 1)) << PAGE_SHIFT) |
                    ADDR_W'($urandom_range(PAGE_BYTES - 1));
    end else if (sel < 86) begin
      r.mode = MODE_REGION;
      case ($urandom_range(2))
        0:       r.region_type = RTYPE_BOOT_CODE;
        1:       r.region_type = RTYPE_BOOT_DATA;
        default: r.region_type = RTYPE_CONVENTIONAL;
      endcase
      r.address = (ADDR_W'($urandom_range(MAP_PAGES - 1)) << PAGE_SHIFT) |
                  ADDR_W'($urandom_range(PAGE_BYTES - 1));
      r.page_count = PCOUNT_W'($urandom_range(256));
    end else if (sel < 94) begin
      // wide fields; the range mostly lies past the map
      r.mode = MODE_REGION;
    end
    return r;
  endfunction

  // Offer one item, hold it until taken; returns at a falling edge with valid high
  task automatic push_req(page_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_req.valid <= 1'b0;
      @(negedge clk);
    end
    in_req.valid       <= 1'b1;
    in_req.mode        <= r.mode;
    in_req.address     <= r.address;
    in_req.page_count  <= r.page_count;
    in_req.region_type <= r.region_type;
    do @(posedge clk); while (in_req.ready !== 1'b1);
    sb.note_request(r);
    @(negedge clk);
  endtask

  // Drop valid and wait until every result is back and the block is idle
  task automatic settle();
    in_req.valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reserved(logic [RSV_W-1:0] v);
    settle();
    cfg_wr.valid <= 1'b1;
    cfg_wr.data  <= v;
    do @(posedge clk); while (cfg_wr.ready !== 1'b1);
    sb.set_reserved(v);
    cfg_writes++;
    @(negedge clk);
    cfg_wr.valid <= 1'b0;
  endtask

  initial begin
    logic [RSV_W-1:0] phase_rsv;
    in_req.valid       = 1'b0;
    in_req.mode        = MODE_NOP;
    in_req.address     = '0;
    in_req.page_count  = '0;
    in_req.region_type = '0;
    cfg_wr.valid       = 1'b0;
    cfg_wr.data        = '0;
    out_rsp.ready      = 1'b0;
    rst_n              = 1'b0;
    idle_pct           = 32;
    cycles             = 0;
    cfg_writes         = 0;
    sb = new();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty map, frees below the reserved area, range and double free
    push_req(mk(MODE_NOP, '1, '1, RTYPE_TOP_CODE));
    push_req(mk(MODE_ALLOC, '0, '0, '0));
    push_req(mk(MODE_FREE, '0, '0, '0));
    push_req(mk(MODE_FREE, '0, '0, '0));
    push_req(mk(MODE_ALLOC, '1, '1, '1));
    push_req(mk(MODE_FREE, '1, '0, '0));
    push_req(mk(MODE_FREE, ADDR_W'(MAP_PAGES * PAGE_BYTES), '0, '0));

    // Directed: regions of every kind, clipping and total saturation
    push_req(mk(MODE_REGION, '0, 36'd2048, RTYPE_CONVENTIONAL));
    push_req(mk(MODE_REGION, '0, 36'd2048, RTYPE_CONVENTIONAL));
    push_req(mk(MODE_REGION, ADDR_W'(5000 * PAGE_BYTES), 36'd10, RTYPE_BOOT_CODE));
    push_req(mk(MODE_REGION, ADDR_W'(6000 * PAGE_BYTES + 7), 36'd1, RTYPE_BOOT_DATA));
    push_req(mk(MODE_REGION, ADDR_W'(7000 * PAGE_BYTES), 36'd100, RTYPE_RUNTIME_CODE));
    push_req(mk(MODE_REGION, '0, '0, RTYPE_RESERVED));
    push_req(mk(MODE_REGION, ADDR_W'((MAP_PAGES - 100) * PAGE_BYTES), 36'd200,
                RTYPE_CONVENTIONAL));
    push_req(mk(MODE_ALLOC, '0, '0, '0));
    push_req(mk(MODE_FREE, ADDR_W'(1024 * PAGE_BYTES + 12'hFFF), '0, '0));
    push_req(mk(MODE_REGION, '1, '1, RTYPE_CONVENTIONAL));
    push_req(mk(MODE_REGION, '0, '1, RTYPE_TOP_CODE));
    push_req(mk(MODE_ALLOC, '0, '0, '0));

    // Directed: no reserved area, page zero, whole map freed
    write_reserved('0);
    push_req(mk(MODE_REGION, '0, 36'd64, RTYPE_CONVENTIONAL));
    push_req(mk(MODE_ALLOC, '0, '0, '0));
    push_req(mk(MODE_REGION, '0, PCOUNT_W'(MAP_PAGES), RTYPE_CONVENTIONAL));
    push_req(mk(MODE_NOP, '0, '0, '0));

    // Directed: everything reserved, regions free nothing
    write_reserved(RSV_W'(MAP_PAGES));
    push_req(mk(MODE_REGION, '0, 36'd1000, RTYPE_BOOT_CODE));
    push_req(mk(MODE_ALLOC, '0, '0, '0));

    // Random phases over several reserved sizes; one phase never idles
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       phase_rsv = RSV_W'(MAP_PAGES);
        1:       phase_rsv = RSV_W'($urandom_range(MAP_PAGES - 1, 1));
        2:       phase_rsv = '0;
        default: phase_rsv = RESERVED_RESET;
      endcase
      write_reserved(phase_rsv);
      idle_pct = (ph == 2) ? 0 : 32;
      repeat (PHASE_ITEMS) push_req(random_req());
    end

    settle();
    repeat (20) @(posedge clk);

    $display("tb: %0d requests: %0d alloc, %0d free, %0d region, %0d no-op; %0d reserved writes",
             sb.mode_count[MODE_ALLOC] + sb.mode_count[MODE_FREE] +
             sb.mode_count[MODE_REGION] + sb.mode_count[MODE_NOP],
             sb.mode_count[MODE_ALLOC], sb.mode_count[MODE_FREE],
             sb.mode_count[MODE_REGION], sb.mode_count[MODE_NOP], cfg_writes);
    $display("tb: %0d results compared, %0d mismatches, %0d cycles",
             sb.checked, sb.errors, cycles);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_if.sv
hw/rtl/bpa_ram.sv
hw/rtl/bpa_dp.sv
hw/rtl/bpa_ctrl.sv
hw/rtl/bitmap_page_allocator_top.sv
test/bitmap_page_allocator_top_tb.sv
